### sv/lcm_pkg.sv
// shared types, codes and lookup tables of the link connection manager
`default_nettype none

package lcm_pkg;

   localparam int CODE_W     = 3;
   localparam int STATE_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_W    = 16;
   localparam int TIME_W     = 48;
   localparam int MS_W       = 32;
   localparam int EXP_W      = 5;
   localparam int POW_W      = 41;

   localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
   localparam logic [TIME_W-1:0]  TIME_MAX     = '1;
   localparam logic [MS_W-1:0]    MS_ALL_ONES  = '1;
   localparam logic [POW_W-1:0]   MS_PER_SEC   = POW_W'(1000);
   localparam logic [CODE_W-1:0]  CMD_COUNT    = CODE_W'(5);
   localparam logic [CODE_W-1:0]  EVT_COUNT    = CODE_W'(6);
   localparam logic [STATE_W-1:0] STATE_COUNT  = STATE_W'(12);

   typedef enum logic [2:0] {
      OP_COMMAND   = 3'd0,
      OP_EVENT     = 3'd1,
      OP_SUSPECT   = 3'd2,
      OP_BACKOFF   = 3'd3,
      OP_CLEAR     = 3'd4,
      OP_SET_STATE = 3'd5,
      OP_QUERY     = 3'd6
   } op_type;

   typedef enum logic [CODE_W-1:0] {
      CMD_START      = 3'd0,
      CMD_STOP       = 3'd1,
      CMD_CONNECT    = 3'd2,
      CMD_DISCONNECT = 3'd3,
      CMD_EXIT       = 3'd4
   } cmd_type;

   typedef enum logic [CODE_W-1:0] {
      EVT_STA_START      = 3'd0,
      EVT_STA_STOP       = 3'd1,
      EVT_STA_CONNECT    = 3'd2,
      EVT_STA_DISCONNECT = 3'd3,
      EVT_GOT_IP         = 3'd4,
      EVT_LOST_IP        = 3'd5
   } evt_type;

   typedef enum logic [STATE_W-1:0] {
      ST_UNINIT          = 4'd0,
      ST_INITIALIZING    = 4'd1,
      ST_INITIALIZED     = 4'd2,
      ST_STARTING        = 4'd3,
      ST_STARTED         = 4'd4,
      ST_CONNECTING      = 4'd5,
      ST_CONNECTED_NO_IP = 4'd6,
      ST_CONNECTED_IP    = 4'd7,
      ST_DISCONNECTING   = 4'd8,
      ST_WAIT_RECONNECT  = 4'd9,
      ST_CRED_ERROR      = 4'd10,
      ST_STOPPING        = 4'd11
   } state_type;

   typedef enum logic [1:0] {
      ACT_EXECUTE = 2'd0,
      ACT_SKIP    = 2'd1,
      ACT_ERROR   = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RSSI_GOOD   = 3'd0,
      CSR_RSSI_MEDIUM = 3'd1,
      CSR_RSSI_WEAK   = 3'd2,
      CSR_LIMIT_GOOD  = 3'd3,
      CSR_LIMIT_MED   = 3'd4,
      CSR_LIMIT_WEAK  = 3'd5,
      CSR_MAX_EXP     = 3'd6,
      CSR_MAX_DELAY   = 3'd7
   } csr_index_type;

   localparam logic [4:0] EVB_NONE         = 5'b00000;
   localparam logic [4:0] EVB_STARTED      = 5'b00001;
   localparam logic [4:0] EVB_START_FAILED = 5'b00010;
   localparam logic [4:0] EVB_CONNECTED    = 5'b00100;
   localparam logic [4:0] EVB_DISCONNECTED = 5'b01000;
   localparam logic [4:0] EVB_STOPPED      = 5'b10000;

   typedef struct packed {
      logic signed [7:0] rssi_good;
      logic signed [7:0] rssi_medium;
      logic signed [7:0] rssi_weak;
      logic [7:0]        limit_good;
      logic [7:0]        limit_medium;
      logic [7:0]        limit_weak;
      logic [EXP_W-1:0]  max_exp;
      logic [MS_W-1:0]   max_delay;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [CODE_W-1:0]  code;
      logic signed [7:0]  rssi;
      logic [STATE_W-1:0] target_state;
      logic [TIME_W-1:0]  now_ms;
   } item_type;

   typedef struct packed {
      logic [MS_W-1:0]    wait_ms;
      logic [MS_W-1:0]    retry_delay;
      logic               credential_error;
      logic               ready_flag;
      logic               linked_flag;
      logic               active_flag;
      logic [STATE_W-1:0] state_now;
      logic [4:0]         event_bits;
      logic [1:0]         action;
   } result_type;

   typedef struct packed {
      logic sta_ready;
      logic connected;
      logic active;
   } props_type;

   typedef struct packed {
      state_type  to_state;
      logic [4:0] bits;
   } ev_type;

   function automatic action_type cmd_lookup(state_type st, logic [CODE_W-1:0] code);
      logic [9:0] row;
      action_type act;
      // one verdict per command, start in the lowest pair
      unique case (st)
         ST_INITIALIZED:
            row = {ACT_ERROR, ACT_ERROR, ACT_ERROR, ACT_SKIP, ACT_EXECUTE};
         ST_STARTING:
            row = {ACT_ERROR, ACT_ERROR, ACT_ERROR, ACT_EXECUTE, ACT_SKIP};
         ST_STARTED:
            row = {ACT_ERROR, ACT_SKIP, ACT_EXECUTE, ACT_EXECUTE, ACT_SKIP};
         ST_CONNECTING, ST_CONNECTED_NO_IP, ST_CONNECTED_IP:
            row = {ACT_ERROR, ACT_EXECUTE, ACT_SKIP, ACT_EXECUTE, ACT_SKIP};
         ST_DISCONNECTING:
            row = {ACT_ERROR, ACT_SKIP, ACT_ERROR, ACT_EXECUTE, ACT_SKIP};
         ST_WAIT_RECONNECT, ST_CRED_ERROR:
            row = {ACT_ERROR, ACT_EXECUTE, ACT_EXECUTE, ACT_EXECUTE, ACT_SKIP};
         ST_STOPPING:
            row = {ACT_ERROR, ACT_ERROR, ACT_ERROR, ACT_SKIP, ACT_ERROR};
         default:
            row = {ACT_ERROR, ACT_ERROR, ACT_ERROR, ACT_ERROR, ACT_ERROR};
      endcase
      // unknown commands execute
      if (code < CMD_COUNT) begin
         act = action_type'(row[{code, 1'b0} +: 2]);
      end else begin
         act = ACT_EXECUTE;
      end
      return act;
   endfunction

   function automatic ev_type ev_lookup(state_type st, logic [CODE_W-1:0] code);
      ev_type ev;
      ev.to_state = st;
      ev.bits     = EVB_NONE;
      unique case (st)
         ST_STARTING: begin
            if (code == EVT_STA_START) begin
               ev.to_state = ST_STARTED;
               ev.bits     = EVB_STARTED;
            end else if (code == EVT_STA_DISCONNECT) begin
               ev.to_state = ST_INITIALIZED;
               ev.bits     = EVB_START_FAILED;
            end
         end
         ST_CONNECTING: begin
            if (code == EVT_STA_CONNECT) begin
               ev.to_state = ST_CONNECTED_NO_IP;
            end else if (code == EVT_STA_DISCONNECT) begin
               ev.to_state = ST_WAIT_RECONNECT;
            end else if (code == EVT_GOT_IP) begin
               ev.to_state = ST_CONNECTED_IP;
               ev.bits     = EVB_CONNECTED;
            end
         end
         ST_CONNECTED_NO_IP: begin
            if (code == EVT_STA_DISCONNECT) begin
               ev.to_state = ST_WAIT_RECONNECT;
            end else if (code == EVT_GOT_IP) begin
               ev.to_state = ST_CONNECTED_IP;
               ev.bits     = EVB_CONNECTED;
            end
         end
         ST_CONNECTED_IP: begin
            if (code == EVT_STA_DISCONNECT) begin
               ev.to_state = ST_WAIT_RECONNECT;
            end else if (code == EVT_LOST_IP) begin
               ev.to_state = ST_CONNECTED_NO_IP;
            end
         end
         ST_DISCONNECTING: begin
            if (code == EVT_STA_DISCONNECT) begin
               ev.to_state = ST_STARTED;
               ev.bits     = EVB_DISCONNECTED;
            end
         end
         ST_STOPPING: begin
            if (code == EVT_STA_STOP) begin
               ev.to_state = ST_INITIALIZED;
               ev.bits     = EVB_STOPPED;
            end
         end
         default: begin
         end
      endcase
      return ev;
   endfunction

   function automatic props_type props_lookup(state_type st);
      props_type pr;
      unique case (st)
         ST_STARTING, ST_STOPPING:
            pr = '{sta_ready: 1'b0, connected: 1'b0, active: 1'b1};
         ST_STARTED, ST_CONNECTING, ST_DISCONNECTING, ST_WAIT_RECONNECT, ST_CRED_ERROR:
            pr = '{sta_ready: 1'b1, connected: 1'b0, active: 1'b1};
         ST_CONNECTED_NO_IP, ST_CONNECTED_IP:
            pr = '{sta_ready: 1'b1, connected: 1'b1, active: 1'b1};
         default:
            pr = '{sta_ready: 1'b0, connected: 1'b0, active: 1'b0};
      endcase
      return pr;
   endfunction

endpackage

`default_nettype wire

### sv/lcm_cfg_regs.sv
// configuration register file of the link connection manager
`default_nettype none

module lcm_cfg_regs
   import lcm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RSSI_GOOD:   cfg_in.rssi_good    = csr_wdata[7:0];
            CSR_RSSI_MEDIUM: cfg_in.rssi_medium  = csr_wdata[7:0];
            CSR_RSSI_WEAK:   cfg_in.rssi_weak    = csr_wdata[7:0];
            CSR_LIMIT_GOOD:  cfg_in.limit_good   = csr_wdata[7:0];
            CSR_LIMIT_MED:   cfg_in.limit_medium = csr_wdata[7:0];
            CSR_LIMIT_WEAK:  cfg_in.limit_weak   = csr_wdata[7:0];
            CSR_MAX_EXP:     cfg_in.max_exp      = csr_wdata[EXP_W-1:0];
            CSR_MAX_DELAY:   cfg_in.max_delay    = csr_wdata[MS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rssi_good    <= -8'sd60;
         cfg_ff.rssi_medium  <= -8'sd75;
         cfg_ff.rssi_weak    <= -8'sd85;
         cfg_ff.limit_good   <= 8'd3;
         cfg_ff.limit_medium <= 8'd5;
         cfg_ff.limit_weak   <= 8'd8;
         cfg_ff.max_exp      <= EXP_W'(5);
         cfg_ff.max_delay    <= MS_W'(60000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### sv/lcm_datapath.sv
// link state machine, counters, backoff and wait computation
`default_nettype none

module lcm_datapath
   import lcm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     step_en,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output result_type    result
);

   state_type            link_state_ff, link_state_in;
   logic [COUNT_W-1:0]   retry_count_ff, retry_count_in;
   logic [COUNT_W-1:0]   suspect_count_ff, suspect_count_in;
   logic [TIME_W-1:0]    deadline_ff, deadline_in;

   ev_type               ev;
   logic [COUNT_W-1:0]   retry_inc;
   logic [COUNT_W-1:0]   suspect_inc;
   logic [7:0]           limit;
   logic                 below_floor;
   logic                 cred_hit;
   logic [EXP_W-1:0]     exponent;
   logic [POW_W-1:0]     pow_delay;
   logic [MS_W-1:0]      delay;
   logic [TIME_W:0]      deadline_sum;
   logic                 deadline_sat;
   logic [TIME_W-1:0]    now_left;
   logic [MS_W-1:0]      backoff_wait;
   logic [TIME_W:0]      remain;
   logic [MS_W-1:0]      stored_wait;
   props_type            props;

   assign ev = ev_lookup(link_state_ff, item.code);

   assign retry_inc   = (retry_count_ff != COUNT_MAX) ? retry_count_ff + 1'b1 : retry_count_ff;
   assign suspect_inc = (suspect_count_ff != COUNT_MAX) ? suspect_count_ff + 1'b1
                                                        : suspect_count_ff;

   // limit by signal strength band
   always_comb begin
      below_floor = 1'b0;
      priority if (item.rssi >= cfg.rssi_good) begin
         limit = cfg.limit_good;
      end else if (item.rssi >= cfg.rssi_medium) begin
         limit = cfg.limit_medium;
      end else if (item.rssi >= cfg.rssi_weak) begin
         limit = cfg.limit_weak;
      end else begin
         limit       = '0;
         below_floor = 1'b1;
      end
   end

   assign cred_hit = !below_floor && (suspect_inc >= {{(COUNT_W-8){1'b0}}, limit});

   // exponent is the retry count before the increment, capped
   assign exponent  = (retry_count_ff >= {{(COUNT_W-EXP_W){1'b0}}, cfg.max_exp})
                      ? cfg.max_exp : retry_count_ff[EXP_W-1:0];
   assign pow_delay = MS_PER_SEC << exponent;
   assign delay     = (pow_delay > {{(POW_W-MS_W){1'b0}}, cfg.max_delay})
                      ? cfg.max_delay : pow_delay[MS_W-1:0];

   assign deadline_sum = {1'b0, item.now_ms} + {{(TIME_W+1-MS_W){1'b0}}, delay};
   assign deadline_sat = deadline_sum[TIME_W];
   assign now_left     = ~item.now_ms;
   // saturated deadline leaves max time minus now
   assign backoff_wait = !deadline_sat ? delay
                       : (now_left[TIME_W-1:MS_W] != '0) ? MS_ALL_ONES : now_left[MS_W-1:0];

   assign remain      = {1'b0, deadline_ff} - {1'b0, item.now_ms};
   assign stored_wait = (deadline_ff <= item.now_ms) ? '0
                      : (remain[TIME_W-1:MS_W] != '0) ? MS_ALL_ONES : remain[MS_W-1:0];

   // next state
   always_comb begin
      link_state_in    = link_state_ff;
      retry_count_in   = retry_count_ff;
      suspect_count_in = suspect_count_ff;
      deadline_in      = deadline_ff;
      unique case (item.op)
         OP_EVENT: begin
            link_state_in = ev.to_state;
         end
         OP_SUSPECT: begin
            suspect_count_in = suspect_inc;
            if (cred_hit) begin
               link_state_in = ST_CRED_ERROR;
            end
         end
         OP_BACKOFF: begin
            retry_count_in = retry_inc;
            deadline_in    = deadline_sat ? TIME_MAX : deadline_sum[TIME_W-1:0];
            link_state_in  = ST_WAIT_RECONNECT;
         end
         OP_CLEAR: begin
            retry_count_in   = '0;
            suspect_count_in = '0;
         end
         OP_SET_STATE: begin
            if (item.target_state < STATE_COUNT) begin
               link_state_in = state_type'(item.target_state);
            end
         end
         default: begin
         end
      endcase
   end

   assign props = props_lookup(link_state_in);

   // result
   always_comb begin
      result                  = '0;
      result.state_now        = link_state_in;
      result.active_flag      = props.active;
      result.linked_flag      = props.connected;
      result.ready_flag       = props.sta_ready;
      unique case (item.op)
         OP_COMMAND: result.action           = cmd_lookup(link_state_ff, item.code);
         OP_EVENT:   result.event_bits       = ev.bits;
         OP_SUSPECT: result.credential_error = cred_hit;
         OP_BACKOFF: result.retry_delay      = delay;
         default: begin
         end
      endcase
      if (link_state_in != ST_WAIT_RECONNECT) begin
         result.wait_ms = MS_ALL_ONES;
      end else if (item.op == OP_BACKOFF) begin
         result.wait_ms = backoff_wait;
      end else begin
         result.wait_ms = stored_wait;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_state_ff    <= ST_UNINIT;
         retry_count_ff   <= '0;
         suspect_count_ff <= '0;
         deadline_ff      <= '0;
      end else if (step_en) begin
         link_state_ff    <= link_state_in;
         retry_count_ff   <= retry_count_in;
         suspect_count_ff <= suspect_count_in;
         deadline_ff      <= deadline_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      step_en && item.op == OP_CLEAR |=> retry_count_ff == '0 && suspect_count_ff == '0)
      else $error("counters not cleared");

   assert property (@(posedge clock) disable iff (reset)
      step_en && result.credential_error |=> link_state_ff == ST_CRED_ERROR)
      else $error("credential error without state change");

   assert property (@(posedge clock) disable iff (reset)
      step_en && item.op != OP_BACKOFF |=> $stable(deadline_ff))
      else $error("deadline moved outside backoff");

   assert property (@(posedge clock) disable iff (reset)
      result.state_now != ST_WAIT_RECONNECT |-> result.wait_ms == MS_ALL_ONES)
      else $error("wait reported while not waiting");
`endif

endmodule

`default_nettype wire

### sv/link_connection_manager_fsm.sv
// link connection manager: wireless station link control with streaming ports
// req channel carries one operation per transfer: its kind in req_tuser, the
// command or event code, signal strength, target state and current time in
// req_tdata. rsp channel returns exactly one result per request: verdict,
// event bits, state and its flags, credential error, backoff delay and wait.
// csr_we/csr_index/csr_wdata write the thresholds, limits and backoff caps;
// write them only while no request is in flight.
// a request accepted into the input register is stepped into the result register
// when rsp is free, and is then offered on rsp.
// throughput: one request per cycle while rsp is not stalled; the state, counter and
// deadline update is combinational between the input register and result register.
// a stalled rsp holds its result; the input register still takes a transfer
// and fills, then req_tready drops until rsp moves again.
// reset clears the link state to uninitialized, counters and deadline to zero,
// registers to their defaults, and empties both registers.
`default_nettype none

module link_connection_manager_fsm
   import lcm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [63:0]           req_tdata,  // code, rssi, target_state, now_ms, zero pad
   input  wire logic [2:0]            req_tuser,  // op
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [79:0]                rsp_tdata,  // action, event_bits, state_now, active_flag,
                                                  // linked_flag, ready_flag,
                                                  // credential_error, retry_delay, wait_ms, pad
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;
   result_type result;
   cfg_type    cfg;
   logic       advance;
   logic       req_fire;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      item_in.op           = req_tuser;
      item_in.code         = req_tdata[2:0];
      item_in.rssi         = req_tdata[10:3];
      item_in.target_state = req_tdata[14:11];
      item_in.now_ms       = req_tdata[62:15];
   end

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   lcm_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcm_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff};

endmodule

`default_nettype wire

### bench/lcm_result_checker.sv
// result checker for the link connection manager: mirrors its state and compares every result
`timescale 1ns / 1ps

module lcm_result_checker
   import lcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [63:0]           req_tdata,   // code, rssi, target_state, now_ms, zero pad
   input  logic [2:0]            req_tuser,   // op
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [79:0]           rsp_tdata,   // action, event_bits, state_now, active_flag,
                                              // linked_flag, ready_flag,
                                              // credential_error, retry_delay, wait_ms, pad
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    failures,
   output int                    outstanding
);

   localparam int REPORT_LIMIT = 60;

   logic signed [7:0] good_dbm     = -8'sd60;
   logic signed [7:0] medium_dbm   = -8'sd75;
   logic signed [7:0] weak_dbm     = -8'sd85;
   logic [7:0]        good_limit   = 8'd3;
   logic [7:0]        medium_limit = 8'd5;
   logic [7:0]        weak_limit   = 8'd8;
   logic [EXP_W-1:0]  exp_cap      = EXP_W'(5);
   logic [MS_W-1:0]   delay_cap    = MS_W'(60000);

   state_type          link_state      = ST_UNINIT;
   logic [COUNT_W-1:0] retry_total     = '0;
   logic [COUNT_W-1:0] suspect_total   = '0;
   logic [TIME_W-1:0]  reconnect_at_ms = '0;

   result_type reports_due [$];

   function automatic action_type verdict_for(state_type st, logic [CODE_W-1:0] cmd);
      action_type row [5];
      case (st)
         ST_INITIALIZED:
            row = '{ACT_EXECUTE, ACT_SKIP, ACT_ERROR, ACT_ERROR, ACT_ERROR};
         ST_STARTING:
            row = '{ACT_SKIP, ACT_EXECUTE, ACT_ERROR, ACT_ERROR, ACT_ERROR};
         ST_STARTED:
            row = '{ACT_SKIP, ACT_EXECUTE, ACT_EXECUTE, ACT_SKIP, ACT_ERROR};
         ST_CONNECTING, ST_CONNECTED_NO_IP, ST_CONNECTED_IP:
            row = '{ACT_SKIP, ACT_EXECUTE, ACT_SKIP, ACT_EXECUTE, ACT_ERROR};
         ST_DISCONNECTING:
            row = '{ACT_SKIP, ACT_EXECUTE, ACT_ERROR, ACT_SKIP, ACT_ERROR};
         ST_WAIT_RECONNECT, ST_CRED_ERROR:
            row = '{ACT_SKIP, ACT_EXECUTE, ACT_EXECUTE, ACT_EXECUTE, ACT_ERROR};
         ST_STOPPING:
            row = '{ACT_ERROR, ACT_SKIP, ACT_ERROR, ACT_ERROR, ACT_ERROR};
         default:
            row = '{ACT_ERROR, ACT_ERROR, ACT_ERROR, ACT_ERROR, ACT_ERROR};
      endcase
      // commands past the table always go ahead
      if (cmd >= CMD_COUNT) begin
         return ACT_EXECUTE;
      end
      return row[cmd];
   endfunction

   function automatic result_type link_result_for(logic [2:0] op, logic [CODE_W-1:0] code,
         logic signed [7:0] rssi, logic [STATE_W-1:0] target, logic [TIME_W-1:0] now_ms);
      result_type         r;
      logic [7:0]         limit;
      logic               too_weak;
      logic [COUNT_W-1:0] exponent;
      logic [63:0]        delay;
      logic [TIME_W-1:0]  remaining;
      r = '0;
      limit = '0;
      too_weak = 1'b0;
      case (op)
         OP_COMMAND: begin
            r.action = verdict_for(link_state, code);
         end
         OP_EVENT: begin
            case (link_state)
               ST_STARTING: begin
                  if (code == EVT_STA_START) begin
                     link_state = ST_STARTED;
                     r.event_bits = EVB_STARTED;
                  end else if (code == EVT_STA_DISCONNECT) begin
                     link_state = ST_INITIALIZED;
                     r.event_bits = EVB_START_FAILED;
                  end
               end
               ST_CONNECTING, ST_CONNECTED_NO_IP: begin
                  if (code == EVT_STA_CONNECT) begin
                     link_state = ST_CONNECTED_NO_IP;
                  end else if (code == EVT_STA_DISCONNECT) begin
                     link_state = ST_WAIT_RECONNECT;
                  end else if (code == EVT_GOT_IP) begin
                     link_state = ST_CONNECTED_IP;
                     r.event_bits = EVB_CONNECTED;
                  end
               end
               ST_CONNECTED_IP: begin
                  if (code == EVT_STA_DISCONNECT) begin
                     link_state = ST_WAIT_RECONNECT;
                  end else if (code == EVT_LOST_IP) begin
                     link_state = ST_CONNECTED_NO_IP;
                  end
               end
               ST_DISCONNECTING: begin
                  if (code == EVT_STA_DISCONNECT) begin
                     link_state = ST_STARTED;
                     r.event_bits = EVB_DISCONNECTED;
                  end
               end
               ST_STOPPING: begin
                  if (code == EVT_STA_STOP) begin
                     link_state = ST_INITIALIZED;
                     r.event_bits = EVB_STOPPED;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_SUSPECT: begin
            if (suspect_total != COUNT_MAX) begin
               suspect_total = suspect_total + 1'b1;
            end
            if (rssi >= good_dbm) begin
               limit = good_limit;
            end else if (rssi >= medium_dbm) begin
               limit = medium_limit;
            end else if (rssi >= weak_dbm) begin
               limit = weak_limit;
            end else begin
               too_weak = 1'b1;
            end
            if (!too_weak && suspect_total >= COUNT_W'(limit)) begin
               link_state = ST_CRED_ERROR;
               r.credential_error = 1'b1;
            end
         end
         OP_BACKOFF: begin
            if (retry_total != COUNT_MAX) begin
               retry_total = retry_total + 1'b1;
            end
            exponent = retry_total - 1'b1;
            if (exponent > COUNT_W'(exp_cap)) begin
               exponent = COUNT_W'(exp_cap);
            end
            delay = 64'(MS_PER_SEC) << exponent;
            if (delay > 64'(delay_cap)) begin
               delay = 64'(delay_cap);
            end
            r.retry_delay = delay[MS_W-1:0];
            if (now_ms > TIME_MAX - delay[TIME_W-1:0]) begin
               reconnect_at_ms = TIME_MAX;
            end else begin
               reconnect_at_ms = now_ms + delay[TIME_W-1:0];
            end
            link_state = ST_WAIT_RECONNECT;
         end
         OP_CLEAR: begin
            retry_total = '0;
            suspect_total = '0;
         end
         OP_SET_STATE: begin
            if (target < STATE_COUNT) begin
               link_state = state_type'(target);
            end
         end
         default: begin
         end
      endcase

      if (link_state != ST_WAIT_RECONNECT) begin
         r.wait_ms = MS_ALL_ONES;
      end else if (reconnect_at_ms > now_ms) begin
         remaining = reconnect_at_ms - now_ms;
         r.wait_ms = (remaining > TIME_W'(MS_ALL_ONES)) ? MS_ALL_ONES : remaining[MS_W-1:0];
      end else begin
         r.wait_ms = '0;
      end

      case (link_state)
         ST_STARTING, ST_STOPPING: begin
            r.active_flag = 1'b1;
         end
         ST_STARTED, ST_CONNECTING, ST_DISCONNECTING, ST_WAIT_RECONNECT, ST_CRED_ERROR: begin
            r.active_flag = 1'b1;
            r.ready_flag = 1'b1;
         end
         ST_CONNECTED_NO_IP, ST_CONNECTED_IP: begin
            r.active_flag = 1'b1;
            r.ready_flag = 1'b1;
            r.linked_flag = 1'b1;
         end
         default: begin
         end
      endcase
      r.state_now = link_state;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
         input logic [31:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      result_type got;
      if (reset) begin
         good_dbm        = -8'sd60;
         medium_dbm      = -8'sd75;
         weak_dbm        = -8'sd85;
         good_limit      = 8'd3;
         medium_limit    = 8'd5;
         weak_limit      = 8'd8;
         exp_cap         = EXP_W'(5);
         delay_cap       = MS_W'(60000);
         link_state      = ST_UNINIT;
         retry_total     = '0;
         suspect_total   = '0;
         reconnect_at_ms = '0;
         reports_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RSSI_GOOD:   good_dbm     = csr_wdata[7:0];
               CSR_RSSI_MEDIUM: medium_dbm   = csr_wdata[7:0];
               CSR_RSSI_WEAK:   weak_dbm     = csr_wdata[7:0];
               CSR_LIMIT_GOOD:  good_limit   = csr_wdata[7:0];
               CSR_LIMIT_MED:   medium_limit = csr_wdata[7:0];
               CSR_LIMIT_WEAK:  weak_limit   = csr_wdata[7:0];
               CSR_MAX_EXP:     exp_cap      = csr_wdata[EXP_W-1:0];
               CSR_MAX_DELAY:   delay_cap    = csr_wdata[MS_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            reports_due.push_back(link_result_for(req_tuser, req_tdata[2:0], req_tdata[10:3],
                                                  req_tdata[14:11], req_tdata[62:15]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[78:0]);
            if (reports_due.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("%0t ns: unexpected result, expected none, actual %h",
                           $time, rsp_tdata);
               end
            end else begin
               want = reports_due.pop_front();
               compare_field("action", want.action, got.action);
               compare_field("event_bits", want.event_bits, got.event_bits);
               compare_field("state_now", want.state_now, got.state_now);
               compare_field("active_flag", want.active_flag, got.active_flag);
               compare_field("linked_flag", want.linked_flag, got.linked_flag);
               compare_field("ready_flag", want.ready_flag, got.ready_flag);
               compare_field("credential_error", want.credential_error,
                             got.credential_error);
               compare_field("retry_delay", want.retry_delay, got.retry_delay);
               compare_field("wait_ms", want.wait_ms, got.wait_ms);
            end
         end
      end
      outstanding <= reports_due.size();
   end

endmodule

### bench/link_connection_manager_fsm_tb.sv
// testbench top for the link connection manager: drives requests and register writes
`timescale 1ns / 1ps

module link_connection_manager_fsm_tb;
   import lcm_pkg::*;

   localparam int PHASES         = 5;
   localparam int PHASE_ITEMS    = 135;
   localparam int CYCLE_LIMIT    = 20000;
   localparam int SETTLE_CYCLES  = 8;

   localparam logic [2:0]        OP_UNUSED     = 3'd7;
   localparam logic [CODE_W-1:0] CODE_NO_EVENT = 3'd6;
   localparam logic [CODE_W-1:0] CODE_TOP      = 3'd7;
   localparam logic [STATE_W-1:0] TARGET_PAST  = 4'd12;
   localparam logic [STATE_W-1:0] TARGET_TOP   = 4'd15;

   typedef enum {SET_RANDOM, SET_LOWEST, SET_HIGHEST} setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata  = '0;   // code, rssi, target_state, now_ms, zero pad
   logic [2:0]            req_tuser  = '0;   // op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [79:0]           rsp_tdata;         // action, event_bits, state_now, active_flag,
                                             // linked_flag, ready_flag,
                                             // credential_error, retry_delay, wait_ms, pad
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int failures;
   int outstanding;
   int items_sent  = 0;
   int cycle_count = 0;
   logic steady = 1'b0;
   logic [TIME_W-1:0] clock_ms = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   link_connection_manager_fsm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lcm_result_checker results (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 6);
   end

   // mostly a slowly running clock, now and then a jump anywhere or to the top
   function automatic logic [TIME_W-1:0] next_now();
      int pick;
      pick = $urandom_range(0, 99);
      clock_ms = clock_ms + TIME_W'($urandom_range(0, 4000));
      if (pick < 8) begin
         return TIME_W'({$urandom, $urandom});
      end
      if (pick < 12) begin
         return TIME_MAX - TIME_W'($urandom_range(0, 5000));
      end
      return clock_ms;
   endfunction

   task automatic send_item(input logic [2:0] op, input logic [CODE_W-1:0] code,
         input logic [7:0] rssi, input logic [STATE_W-1:0] target,
         input logic [TIME_W-1:0] now);
      while (!steady && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, now, target, rssi, code};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic settle();
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(input setting_type kind);
      case (kind)
         SET_LOWEST: begin
            write_reg(CSR_RSSI_GOOD, 32'h80);
            write_reg(CSR_RSSI_MEDIUM, 32'h80);
            write_reg(CSR_RSSI_WEAK, 32'h80);
            write_reg(CSR_LIMIT_GOOD, 32'h0);
            write_reg(CSR_LIMIT_MED, 32'h0);
            write_reg(CSR_LIMIT_WEAK, 32'h0);
            write_reg(CSR_MAX_EXP, 32'h0);
            write_reg(CSR_MAX_DELAY, 32'h0);
         end
         SET_HIGHEST: begin
            write_reg(CSR_RSSI_GOOD, 32'h7f);
            write_reg(CSR_RSSI_MEDIUM, 32'h7f);
            write_reg(CSR_RSSI_WEAK, 32'h7f);
            write_reg(CSR_LIMIT_GOOD, 32'hff);
            write_reg(CSR_LIMIT_MED, 32'hff);
            write_reg(CSR_LIMIT_WEAK, 32'hff);
            write_reg(CSR_MAX_EXP, 32'd22);
            write_reg(CSR_MAX_DELAY, 32'hffff_ffff);
         end
         default: begin
            write_reg(CSR_RSSI_GOOD, 32'($urandom_range(0, 255)));
            write_reg(CSR_RSSI_MEDIUM, 32'($urandom_range(0, 255)));
            write_reg(CSR_RSSI_WEAK, 32'($urandom_range(0, 255)));
            // small limits make credential errors frequent
            write_reg(CSR_LIMIT_GOOD, 32'($urandom_range(0, 12)));
            write_reg(CSR_LIMIT_MED, 32'($urandom_range(0, 255)));
            write_reg(CSR_LIMIT_WEAK, 32'($urandom_range(0, 20)));
            write_reg(CSR_MAX_EXP, 32'($urandom_range(0, 22)));
            if ($urandom_range(0, 1) == 0) begin
               write_reg(CSR_MAX_DELAY, 32'($urandom_range(0, 300000)));
            end else begin
               write_reg(CSR_MAX_DELAY, $urandom);
            end
         end
      endcase
      csr_we <= 1'b0;
   endtask

   task automatic send_random_item();
      int pick;
      logic [2:0] op;
      logic [CODE_W-1:0] code;
      logic [STATE_W-1:0] target;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         op = OP_SET_STATE;
      end else if (pick < 40) begin
         op = OP_EVENT;
      end else if (pick < 58) begin
         op = OP_COMMAND;
      end else if (pick < 73) begin
         op = OP_SUSPECT;
      end else if (pick < 85) begin
         op = OP_BACKOFF;
      end else if (pick < 90) begin
         op = OP_CLEAR;
      end else if (pick < 97) begin
         op = OP_QUERY;
      end else begin
         op = OP_UNUSED;
      end
      if ($urandom_range(0, 9) == 0) begin
         code = CODE_W'($urandom_range(0, 7));
      end else begin
         code = CODE_W'($urandom_range(0, 5));
      end
      if ($urandom_range(0, 9) == 0) begin
         target = STATE_W'($urandom_range(0, 15));
      end else begin
         target = STATE_W'($urandom_range(0, ST_STOPPING));
      end
      send_item(op, code, 8'($urandom), target, next_now());
   endtask

   // a plausible link lifetime: start, connect, get an address, drop and back off
   task automatic run_link_session();
      send_item(OP_SET_STATE, 3'($urandom), 8'($urandom), ST_STARTING, next_now());
      send_item(OP_EVENT, EVT_STA_START, 8'($urandom), 4'($urandom), next_now());
      send_item(OP_COMMAND, CMD_CONNECT, 8'($urandom), 4'($urandom), next_now());
      send_item(OP_SET_STATE, 3'($urandom), 8'($urandom), ST_CONNECTING, next_now());
      send_item(OP_EVENT, EVT_STA_CONNECT, 8'($urandom), 4'($urandom), next_now());
      send_item(OP_EVENT, EVT_GOT_IP, 8'($urandom), 4'($urandom), next_now());
      repeat ($urandom_range(0, 3)) send_random_item();
      send_item(OP_EVENT, EVT_STA_DISCONNECT, 8'($urandom), 4'($urandom), next_now());
      send_item(OP_BACKOFF, 3'($urandom), 8'($urandom), 4'($urandom), next_now());
      send_item(OP_QUERY, 3'($urandom), 8'($urandom), 4'($urandom), next_now());
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int phase_end;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed pass at register defaults
      send_item(OP_QUERY, CMD_START, 8'h00, ST_UNINIT, 48'd0);
      send_item(OP_COMMAND, CMD_START, 8'h00, ST_UNINIT, 48'd10);
      send_item(OP_COMMAND, CODE_TOP, 8'hff, ST_UNINIT, 48'd20);
      send_item(OP_SET_STATE, CMD_START, 8'h00, TARGET_PAST, 48'd30);
      send_item(OP_SET_STATE, CMD_START, 8'h00, TARGET_TOP, 48'd40);
      send_item(OP_SET_STATE, CMD_START, 8'h00, ST_STARTING, 48'd50);
      send_item(OP_EVENT, EVT_STA_START, 8'h00, ST_UNINIT, 48'd60);
      send_item(OP_SET_STATE, CMD_START, 8'h00, ST_STARTING, 48'd70);
      send_item(OP_EVENT, EVT_STA_DISCONNECT, 8'h00, ST_UNINIT, 48'd80);
      send_item(OP_SET_STATE, CMD_START, 8'h00, ST_CONNECTING, 48'd90);
      send_item(OP_EVENT, EVT_STA_CONNECT, 8'h00, ST_UNINIT, 48'd100);
      send_item(OP_EVENT, EVT_GOT_IP, 8'h00, ST_UNINIT, 48'd110);
      send_item(OP_EVENT, EVT_LOST_IP, 8'h00, ST_UNINIT, 48'd120);
      send_item(OP_EVENT, CODE_NO_EVENT, 8'h00, ST_UNINIT, 48'd130);
      send_item(OP_EVENT, CODE_TOP, 8'h00, ST_UNINIT, 48'd140);
      send_item(OP_EVENT, EVT_STA_DISCONNECT, 8'h00, ST_UNINIT, 48'd150);
      send_item(OP_SET_STATE, CMD_START, 8'h00, ST_DISCONNECTING, 48'd160);
      send_item(OP_EVENT, EVT_STA_DISCONNECT, 8'h00, ST_UNINIT, 48'd170);
      send_item(OP_COMMAND, CMD_EXIT, 8'h00, ST_UNINIT, 48'd180);
      send_item(OP_SET_STATE, CMD_START, 8'h00, ST_STOPPING, 48'd190);
      send_item(OP_EVENT, EVT_STA_STOP, 8'h00, ST_UNINIT, 48'd200);
      // weak signal counts but never flags, then strong signal reaches the limit
      send_item(OP_SUSPECT, CMD_START, 8'h80, ST_UNINIT, 48'd210);
      send_item(OP_SUSPECT, CMD_START, 8'h7f, ST_UNINIT, 48'd220);
      send_item(OP_SUSPECT, CMD_START, 8'h7f, ST_UNINIT, 48'd230);
      send_item(OP_BACKOFF, CMD_START, 8'h00, ST_UNINIT, 48'd0);
      // deadline saturates at the top of the time range
      send_item(OP_BACKOFF, CMD_START, 8'h00, ST_UNINIT, TIME_MAX);
      send_item(OP_QUERY, CMD_START, 8'h00, ST_UNINIT, 48'd0);
      send_item(OP_CLEAR, CMD_START, 8'h00, ST_UNINIT, 48'd250);
      send_item(OP_UNUSED, CMD_START, 8'h00, ST_UNINIT, TIME_MAX);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: load_settings(SET_LOWEST);
            2: load_settings(SET_HIGHEST);
            default: load_settings(SET_RANDOM);
         endcase
         steady <= (phase == 3);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 3) == 0) begin
               run_link_session();
            end else begin
               send_random_item();
            end
            if ($urandom_range(0, 149) == 0) begin
               wait_all_results();
            end
         end
         settle();
      end
      steady <= 1'b0;

      // a last stretch at fresh random settings
      load_settings(SET_RANDOM);
      repeat (40) send_random_item();
      settle();

      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
